### rtl/conv3x3_zero_pad_stream_core_macros.svh
// assertion macros for the 3x3 convolution core checker
// no dependencies; pulled in by the checker file only
`ifndef CONV3X3_ZERO_PAD_STREAM_CORE_MACROS_SVH
`define CONV3X3_ZERO_PAD_STREAM_CORE_MACROS_SVH

// holds at every clock edge, reset included
`define C3ZP_ASSERT_ALWAYS(lbl, clk_s, expr) \
	lbl: assert property (@(posedge clk_s) (expr)) else $error("c3zp: check failed");

// consequent in the cycle after the antecedent, off while in reset
`define C3ZP_ASSERT_NEXT(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("c3zp: check failed");

// consequent in the same cycle as the antecedent, off while in reset
`define C3ZP_ASSERT_SAME(lbl, clk_s, rst_n, pre, post) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("c3zp: check failed");

`endif

### rtl/c3zp_pkg.sv
// shared widths, codes, reset values and structs of the 3x3 convolution core
// no dependencies; used by every rtl module of the block
package c3zp_pkg;

	localparam int PIX_W      = 16;
	localparam int COEF_W     = 8;
	localparam int PROD_W     = 24;
	localparam int SUM_W      = 27;
	localparam int NUM_TAPS   = 9;
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT  = 3'd1,
		REG_KERNEL_TOP    = 3'd2,
		REG_KERNEL_MID    = 3'd3,
		REG_KERNEL_BOTTOM = 3'd4
	} cfg_reg_t;

	localparam logic [FW_W-1:0]       FRAME_WIDTH_RST  = 11'd3;
	localparam logic [FH_W-1:0]       FRAME_HEIGHT_RST = 13'd3;
	localparam logic [CFG_DATA_W-1:0] KERN_TOP_RST     = 24'hFF0001;
	localparam logic [CFG_DATA_W-1:0] KERN_MID_RST     = 24'hFE0002;
	localparam logic [CFG_DATA_W-1:0] KERN_BOTTOM_RST  = 24'hFF0001;

	// position of one pixel inside the frame, worked out when it enters
	typedef struct packed {
		logic r_is0;
		logic r_is1;
		logic r_ge_h;
		logic last_row;
		logic c_is0;
		logic c_is1;
		logic c_ge_w;
		logic row_end;
	} pix_flags_t;

	// one column entry of the two line stores
	typedef struct packed {
		logic [PIX_W-1:0] older;
		logic [PIX_W-1:0] newer;
	} line_word_t;

	// masked window taps for one result, tap index = row * 3 + column
	typedef struct packed {
		logic [NUM_TAPS-1:0][PIX_W-1:0] tap;
		logic                           frame_end;
	} mac_op_t;

endpackage

### rtl/c3zp_line_store.sv
// two line stores packed in one memory word, registered read, write-to-read bypass
// depends on c3zp_pkg
module c3zp_line_store #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  logic [c3zp_pkg::PIX_W-1:0] wr_pixel,
	output c3zp_pkg::line_word_t  col
);
	import c3zp_pkg::*;

	line_word_t mem [DEPTH];
	line_word_t rd_q;
	line_word_t byp_word_q;
	line_word_t wr_word;
	logic       byp_q;

	// older row takes what the newer row held, newer row takes the pixel
	assign wr_word = '{older: col.newer, newer: wr_pixel};
	assign col     = byp_q ? byp_word_q : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_word_q <= wr_word;
		end
	end

	// same column written and read at one edge: memory returns stale data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (rd_addr == wr_addr);
		end
	end

endmodule

### rtl/c3zp_window.sv
// 3x3 window registers and result sequencer, one result issued per cycle while op_ready is high
// depends on c3zp_pkg
module c3zp_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       px_valid,
	output logic                       px_ready,
	input  logic [c3zp_pkg::PIX_W-1:0] px,
	input  c3zp_pkg::line_word_t       col,
	input  c3zp_pkg::pix_flags_t       flags,
	output logic                       op_valid,
	input  logic                       op_ready,
	output c3zp_pkg::mac_op_t          op
);
	import c3zp_pkg::*;

	typedef enum logic [1:0] {
		RES_UL = 2'd0,
		RES_UR = 2'd1,
		RES_LL = 2'd2,
		RES_LR = 2'd3
	} res_sel_t;

	logic [2:0][2:0][PIX_W-1:0] win_q;
	logic [2:0][2:0][PIX_W-1:0] cs;
	logic [2:0][2:0][PIX_W-1:0] rs;
	pix_flags_t                 flags_q;
	logic [3:0]                 pend_q;
	logic [3:0]                 pend_new;
	logic [3:0]                 pend_after;
	logic [3:0]                 issue_mask;
	logic [2:0]                 row_keep;
	logic [2:0]                 col_keep;
	res_sel_t                   sel;
	logic                       sel_i;
	logic                       sel_j;
	logic                       issue;
	logic                       load;

	// lowest pending result first: upper-left, upper-right, lower-left, lower-right
	always_comb begin
		if (pend_q[0]) begin
			sel = RES_UL;
		end else if (pend_q[1]) begin
			sel = RES_UR;
		end else if (pend_q[2]) begin
			sel = RES_LL;
		end else begin
			sel = RES_LR;
		end
	end

	assign sel_i      = sel[1];
	assign sel_j      = sel[0];
	assign op_valid   = (pend_q != 4'd0);
	assign issue      = op_valid && op_ready;
	assign issue_mask = issue ? (4'b0001 << sel) : 4'b0000;
	assign pend_after = pend_q & ~issue_mask;
	assign px_ready   = (pend_after == 4'd0);
	assign load       = px_valid && px_ready;

	assign pend_new = {flags.last_row & flags.row_end,
		flags.last_row & ~flags.c_is0,
		~flags.r_is0 & flags.row_end,
		~flags.r_is0 & ~flags.c_is0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			flags_q <= '0;
			pend_q  <= 4'd0;
		end else if (load) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= col.older;
			win_q[1][2] <= col.newer;
			win_q[2][2] <= px;
			flags_q     <= flags;
			pend_q      <= pend_new;
		end else begin
			pend_q <= pend_after;
		end
	end

	// padding: drop taps that fall outside the frame for the selected result
	always_comb begin
		row_keep[0] = sel_i ? ~flags_q.r_is0 : ~flags_q.r_is1;
		row_keep[1] = 1'b1;
		row_keep[2] = sel_i ? 1'b0 : ~flags_q.r_ge_h;
		col_keep[0] = sel_j ? ~flags_q.c_is0 : ~flags_q.c_is1;
		col_keep[1] = 1'b1;
		col_keep[2] = sel_j ? 1'b0 : ~flags_q.c_ge_w;
	end

	// align the window so that tap (1,1) is the selected centre
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			cs[r][0] = sel_j ? win_q[r][1] : win_q[r][0];
			cs[r][1] = sel_j ? win_q[r][2] : win_q[r][1];
			cs[r][2] = sel_j ? '0 : win_q[r][2];
		end
		rs[0] = sel_i ? cs[1] : cs[0];
		rs[1] = sel_i ? cs[2] : cs[1];
		rs[2] = sel_i ? '0 : cs[2];
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				op.tap[dr * 3 + dc] = (row_keep[dr] && col_keep[dc]) ? rs[dr][dc] : '0;
			end
		end
		op.frame_end = (sel == RES_LR);
	end

endmodule

### rtl/c3zp_mac.sv
// nine tap products, registered, then their sum in the output register
// depends on c3zp_pkg
module c3zp_mac (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      op_valid,
	output logic                                      op_ready,
	input  c3zp_pkg::mac_op_t                         op,
	input  logic [2:0][c3zp_pkg::CFG_DATA_W-1:0]      kern,
	output logic                                      result_valid,
	input  logic                                      result_ready,
	output logic signed [c3zp_pkg::SUM_W-1:0]         filtered,
	output logic                                      frame_end
);
	import c3zp_pkg::*;

	logic signed [PROD_W-1:0] a_ext [NUM_TAPS];
	logic signed [PROD_W-1:0] b_ext [NUM_TAPS];
	logic signed [PROD_W-1:0] prod_c [NUM_TAPS];
	logic signed [PROD_W-1:0] prod_s1 [NUM_TAPS];
	logic signed [SUM_W-1:0]  sum_c;
	logic signed [SUM_W-1:0]  filtered_s2;
	logic                     fe_s1;
	logic                     fe_s2;
	logic                     pv_s1;
	logic                     ov_s2;
	logic                     out_adv;

	assign out_adv  = !ov_s2 || result_ready;
	assign op_ready = !pv_s1 || out_adv;

	always_comb begin
		for (int dr = 0; dr < 3; dr++) begin
			for (int dc = 0; dc < 3; dc++) begin
				a_ext[dr * 3 + dc]  = PROD_W'($signed(op.tap[dr * 3 + dc]));
				b_ext[dr * 3 + dc]  = PROD_W'($signed(kern[dr][dc * COEF_W +: COEF_W]));
				prod_c[dr * 3 + dc] = a_ext[dr * 3 + dc] * b_ext[dr * 3 + dc];
			end
		end
	end

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < NUM_TAPS; k++) begin
			sum_c = sum_c + SUM_W'(prod_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (op_valid && op_ready) begin
			prod_s1 <= prod_c;
			fe_s1   <= op.frame_end;
		end
		if (pv_s1 && out_adv) begin
			filtered_s2 <= sum_c;
			fe_s2       <= fe_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
			ov_s2 <= 1'b0;
		end else begin
			if (op_ready) begin
				pv_s1 <= op_valid;
			end
			if (out_adv) begin
				ov_s2 <= pv_s1;
			end
		end
	end

	assign result_valid = ov_s2;
	assign filtered     = filtered_s2;
	assign frame_end    = fe_s2;

endmodule

### rtl/conv3x3_zero_pad_stream_core.sv
// streaming 3x3 convolution with zero padding, signed pixels in raster order
// pipeline: input register, window registers, product register, output register
// throughput: one pixel per cycle while no results wait; a pixel with more than one result
//   holds the input for the single multiply-accumulate unit: one result per cycle unless stalled
// reset: arst_n clears counters, window, valids and loads the default size and kernel
module conv3x3_zero_pad_stream_core #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pixel_valid,
	output logic                                  pixel_ready,
	input  logic signed [c3zp_pkg::PIX_W-1:0]     pixel,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic signed [c3zp_pkg::SUM_W-1:0]     filtered,
	output logic                                  frame_end,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [c3zp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [c3zp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import c3zp_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	// configuration registers
	logic [FW_W-1:0]       frame_width_q;
	logic [FH_W-1:0]       frame_height_q;
	logic [CFG_DATA_W-1:0] kern_top_q;
	logic [CFG_DATA_W-1:0] kern_mid_q;
	logic [CFG_DATA_W-1:0] kern_bot_q;

	// frame position and effective size
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [31:0]   col_inc;
	logic [31:0]   row_inc;
	pix_flags_t    flags_in;

	// input register stage
	logic             valid_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [CW-1:0]    idx_s1;
	pix_flags_t       flags_s1;

	logic                        in_acc;
	logic                        win_ready;
	logic                        s1_adv;
	line_word_t                  col_word;
	logic                        op_valid;
	logic                        op_ready;
	mac_op_t                     op;
	logic [2:0][CFG_DATA_W-1:0]  kern;

	// config port never stalls; writes must land while the block is idle, a rule the block leaves to the user
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			kern_top_q     <= KERN_TOP_RST;
			kern_mid_q     <= KERN_MID_RST;
			kern_bot_q     <= KERN_BOTTOM_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data[FW_W-1:0];
				end
				REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data[FH_W-1:0];
				end
				REG_KERNEL_TOP: begin
					kern_top_q <= cfg_data;
				end
				REG_KERNEL_MID: begin
					kern_mid_q <= cfg_data;
				end
				REG_KERNEL_BOTTOM: begin
					kern_bot_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// zero size acts as one, oversize saturates at the line store depth / row limit
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(frame_height_q);
		end
	end

	// where the incoming pixel sits; a counter past a shrunk size ends its row or frame
	assign col_inc = 32'(col_q) + 32'd1;
	assign row_inc = 32'(row_q) + 32'd1;

	always_comb begin
		flags_in.r_is0    = (row_q == '0);
		flags_in.r_is1    = (row_q == RW'(1));
		flags_in.r_ge_h   = (32'(row_q) >= 32'(h_eff));
		flags_in.last_row = (row_inc >= 32'(h_eff));
		flags_in.c_is0    = (col_q == '0);
		flags_in.c_is1    = (col_q == CW'(1));
		flags_in.c_ge_w   = (32'(col_q) >= 32'(w_eff));
		flags_in.row_end  = (col_inc >= 32'(w_eff));
	end

	// input beat handshake: the stage frees up as soon as the window takes its pixel
	assign s1_adv      = valid_s1 && win_ready;
	assign pixel_ready = !valid_s1 || win_ready;
	assign in_acc      = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (pixel_ready) begin
				valid_s1 <= pixel_valid;
			end
			if (in_acc) begin
				if (flags_in.row_end) begin
					col_q <= '0;
					row_q <= flags_in.last_row ? '0 : RW'(row_inc);
				end else begin
					col_q <= CW'(col_inc);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pixel_s1 <= pixel;
			idx_s1   <= col_q;
			flags_s1 <= flags_in;
		end
	end

	// line stores: read the column on acceptance, rotate it when the window takes the pixel
	c3zp_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (in_acc),
		.rd_addr  (col_q),
		.wr_en    (s1_adv),
		.wr_addr  (idx_s1),
		.wr_pixel (pixel_s1),
		.col      (col_word)
	);

	// window shift and up to four results per pixel, one issued a cycle while the multiply-accumulate unit is ready
	c3zp_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.px_valid (valid_s1),
		.px_ready (win_ready),
		.px       (pixel_s1),
		.col      (col_word),
		.flags    (flags_s1),
		.op_valid (op_valid),
		.op_ready (op_ready),
		.op       (op)
	);

	// kernel rows: index 0 is the row above
	assign kern = {kern_bot_q, kern_mid_q, kern_top_q};

	// product stage then sum into the output register, which parts the result side
	c3zp_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op_ready     (op_ready),
		.op           (op),
		.kern         (kern),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.filtered     (filtered),
		.frame_end    (frame_end)
	);

endmodule

### rtl/c3zp_checker.sv
// port-level checks of the 3x3 convolution core, bound to the top level
// depends on c3zp_pkg and conv3x3_zero_pad_stream_core_macros.svh
`include "conv3x3_zero_pad_stream_core_macros.svh"

module c3zp_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              pixel_valid,
	input logic                              pixel_ready,
	input logic                              result_valid,
	input logic                              result_ready,
	input logic signed [c3zp_pkg::SUM_W-1:0] filtered,
	input logic                              frame_end
);

	logic any_pix_q;

	// set once any pixel beat has gone in since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_pix_q <= 1'b0;
		end else if (pixel_valid && pixel_ready) begin
			any_pix_q <= 1'b1;
		end
	end

	// output register empty while reset is held
	`C3ZP_ASSERT_ALWAYS(a_reset_no_result, clk, !arst_n |-> !result_valid)
	// a stalled result beat keeps its payload
	`C3ZP_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready, result_valid && $stable(filtered) && $stable(frame_end))
	// no result without some pixel having entered
	`C3ZP_ASSERT_SAME(a_no_orphan_result, clk, arst_n, result_valid, any_pix_q)

endmodule

bind conv3x3_zero_pad_stream_core c3zp_checker u_c3zp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.filtered     (filtered),
	.frame_end    (frame_end)
);
